>>> hdl/text_console_writer_assert.svh
// Assertion shorthands used by the console RTL; the using module
// provides aclk and aresetn.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Check that a condition implies an expression in the same cycle.
`define TCW_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define TCW_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
package tcw_pkg;

    // Fixed field widths of the ports
    localparam int CELL_W    = 16;
    localparam int GLYPH_W   = 8;
    localparam int ATTR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Character and attribute codes
    localparam logic [GLYPH_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [GLYPH_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0]  LIGHT_GREY   = 8'd7;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = {LIGHT_GREY, SPACE_CODE};

    // Item operations
    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // One result item
    typedef struct packed {
        logic [CELL_W-1:0]    cell_word;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
    } res_t;

endpackage

>>> hdl/tcw_screen_ram.sv
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tcw_seq.sv
module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    localparam int CELL_COUNT = COLUMNS * ROWS,
    localparam int ADDR_W     = $clog2(CELL_COUNT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // item input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [tcw_pkg::GLYPH_W-1:0] s_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] s_cell_index,
    // current attribute
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    // result toward the output register
    output logic                        res_valid,
    input  logic                        res_ready,
    output tcw_pkg::res_t               res,
    // screen memory
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_FILL  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ADDR_W-1:0]          base_reg, base_next;
    logic [ADDR_W-1:0]          ptr_reg, ptr_next;
    logic                       cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]          cp_addr_reg, cp_addr_next;
    logic [tcw_pkg::ATTR_W-1:0] fill_attr_reg, fill_attr_next;
    logic                       res_valid_reg, res_valid_next;
    tcw_pkg::res_t              res_reg, res_next;

    logic accept;
    logic idx_ok;

    assign s_ready   = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = s_valid && s_ready;
    assign idx_ok    = 32'(s_cell_index) < CELL_COUNT;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequence items, scrolls and the clearing pass
    always_comb begin
        logic wrap;
        wrap           = 1'b0;
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        ptr_next       = ptr_reg;
        cp_valid_next  = 1'b0;
        cp_addr_next   = cp_addr_reg;
        fill_attr_next = fill_attr_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = tcw_pkg::BLANK_CELL;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg + ROW_STEP;

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_CELL) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == tcw_pkg::OP_READ) begin
                        if (idx_ok) begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(s_cell_index);
                            state_next = ST_READ;
                        end else begin
                            res_valid_next         = 1'b1;
                            res_next.cell_word     = '0;
                            res_next.cursor_row    = tcw_pkg::ROW_OUT_W'(row_reg);
                            res_next.cursor_column = tcw_pkg::COL_OUT_W'(col_reg);
                        end
                    end else begin
                        if (s_char_code == tcw_pkg::NEWLINE_CODE) begin
                            wrap = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = base_reg + ADDR_W'(col_reg);
                            mem_wdata = {attr, s_char_code};
                            if (col_reg == LAST_COL) begin
                                wrap = 1'b1;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        // move down a line, or scroll from the bottom row
                        if (wrap) begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                ptr_next       = '0;
                                fill_attr_next = attr;
                                state_next     = ST_COPY;
                            end else begin
                                row_next  = row_reg + ROW_W'(1);
                                base_next = base_reg + ROW_STEP;
                            end
                        end
                        res_valid_next         = 1'b1;
                        res_next.cell_word     = '0;
                        res_next.cursor_row    = tcw_pkg::ROW_OUT_W'(row_next);
                        res_next.cursor_column = tcw_pkg::COL_OUT_W'(col_next);
                    end
                end
            end
            ST_READ: begin
                res_valid_next         = 1'b1;
                res_next.cell_word     = mem_rdata;
                res_next.cursor_row    = tcw_pkg::ROW_OUT_W'(row_reg);
                res_next.cursor_column = tcw_pkg::COL_OUT_W'(col_reg);
                state_next             = ST_IDLE;
            end
            ST_COPY: begin
                // read one row below, write back on the next cycle
                mem_re        = 1'b1;
                cp_valid_next = 1'b1;
                cp_addr_next  = ptr_reg;
                if (ptr_reg == COPY_LAST) begin
                    ptr_next   = FILL_BASE;
                    state_next = ST_FILL;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_FILL: begin
                if (!cp_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = {fill_attr_reg, tcw_pkg::SPACE_CODE};
                    if (ptr_reg == LAST_CELL) begin
                        ptr_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // finish the pending row copy
        if (cp_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = cp_addr_reg;
            mem_wdata = mem_rdata;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            ptr_reg       <= '0;
            cp_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            ptr_reg       <= ptr_next;
            cp_valid_reg  <= cp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        cp_addr_reg   <= cp_addr_next;
        fill_attr_reg <= fill_attr_next;
        res_reg       <= res_next;
    end

`include "text_console_writer_assert.svh"

    `TCW_ASSERT_SAME(a_cursor_range, 1'b1, (row_reg <= LAST_ROW) && (col_reg <= LAST_COL), "cursor out of screen")
    `TCW_ASSERT_SAME(a_row_base, 1'b1, int'(base_reg) == int'(row_reg) * COLUMNS, "row base does not match cursor row")
    `TCW_ASSERT_SAME(a_copy_order, (state_reg == ST_COPY) && cp_valid_reg, mem_waddr < mem_raddr, "row copy writes ahead of its reads")
    `TCW_ASSERT_NEXT(a_read_slot, accept && (s_opcode == tcw_pkg::OP_READ) && idx_ok, (state_reg == ST_READ) && !res_valid_reg, "read data would overwrite a pending result")

endmodule

>>> hdl/text_console_writer.sv
// Text console with a COLUMNS x ROWS screen of 16-bit cells (glyph in bits 7..0,
// attribute in bits 15..8) held in one single-port-write, single-port-read RAM.
// Put and newline items may follow back to back while results are taken; a read
// item in range waits for the registered RAM read before the next item is accepted.
// A put or newline that moves down from the bottom row scrolls the screen: its
// result is given at once, but no further item is taken until the rows are copied
// up and the bottom row is blanked, one cell copied or blanked per cycle through
// the RAM's single write port. After reset the block clears the screen to light
// grey spaces, one cell per cycle, before it takes the first item; attribute
// writes are taken at any time and apply to later puts and scrolls.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // attribute register
    input  logic                          cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
    // item input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [tcw_pkg::GLYPH_W-1:0]   s_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   s_cell_index,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcw_pkg::CELL_W-1:0]    m_cell_word,
    output logic [tcw_pkg::ROW_OUT_W-1:0] m_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0] m_cursor_column
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic                       out_valid_reg;
    tcw_pkg::res_t              out_reg;

    logic                       res_valid;
    logic                       res_ready;
    tcw_pkg::res_t              res;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    // Hold the attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcw_pkg::LIGHT_GREY;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    // Output register: take a result when empty or being drained
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_cell_word     = out_reg.cell_word;
    assign m_cursor_row    = out_reg.cursor_row;
    assign m_cursor_column = out_reg.cursor_column;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .attr         (attr_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule
